// ----- hw/rtl/lg_pkg.sv -----
// ============================================================================
// lg_pkg: shared types and constants for the life automaton grid
// Grid geometry, item kinds, the row cell control word and the B3/S23
// next-row function used by every row cell.
// ============================================================================
package lg_pkg;

   localparam int GRID_COLUMNS = 64;   // 3 .. 64
   localparam int GRID_ROWS    = 16;   // 3 .. 16

   localparam int ROW_IDX_W = $clog2(GRID_ROWS);
   localparam int COL_IDX_W = $clog2(GRID_COLUMNS);

   localparam int KIND_W   = 2;
   localparam int COORD_W  = 8;
   localparam int ROW_NUM_W = 4;
   localparam int ROW_OUT_W = 64;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_KILL  = 2'd1,
      KIND_SPAWN = 2'd2,
      KIND_STEP  = 2'd3
   } kind_type;

   typedef logic [GRID_COLUMNS-1:0] row_type;

   // Broadcast to every row cell; kill/spawn act only in the selected cell.
   typedef struct packed {
      logic clear;
      logic step;
      logic shift;
      logic kill;
      logic spawn;
   } cell_ctrl_type;

   // Next generation of one row from the rows above and below.
   // Out-of-grid neighbors are dead: the rows are padded with a zero on
   // each side, and missing rows come in as zero.
   function automatic row_type life_row(input row_type above,
                                        input row_type mid,
                                        input row_type below);
      logic [GRID_COLUMNS+1:0] a;
      logic [GRID_COLUMNS+1:0] m;
      logic [GRID_COLUMNS+1:0] b;
      row_type                 nxt;
      logic [3:0]              n;
      a = {1'b0, above, 1'b0};
      m = {1'b0, mid, 1'b0};
      b = {1'b0, below, 1'b0};
      nxt = '0;
      for (int x = 0; x < GRID_COLUMNS; x++) begin
         n = 4'(a[x]) + 4'(a[x+1]) + 4'(a[x+2])
           + 4'(m[x]) + 4'(m[x+2])
           + 4'(b[x]) + 4'(b[x+1]) + 4'(b[x+2]);
         nxt[x] = (n == 4'd3) || (m[x+1] && (n == 4'd2));
      end
      return nxt;
   endfunction

endpackage

// ----- hw/rtl/lg_if.sv -----
// ============================================================================
// lg_if: valid/ready channels of the life automaton grid
// lg_req_if carries one command item, lg_rsp_if one row of the grid dump.
// ============================================================================
interface lg_req_if import lg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [COORD_W-1:0]   cell_x;
   logic [COORD_W-1:0]   cell_y;

   modport source (output valid, output kind, output cell_x, output cell_y,
                   input ready);
   modport sink   (input valid, input kind, input cell_x, input cell_y,
                   output ready);
endinterface

interface lg_rsp_if import lg_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ROW_NUM_W-1:0]   row_index;
   logic [ROW_OUT_W-1:0]   row_cells;
   logic                   last_row;
   logic                   status;

   modport source (output valid, output row_index, output row_cells,
                   output last_row, output status, input ready);
   modport sink   (input valid, input row_index, input row_cells,
                   input last_row, input status, output ready);
endinterface

// ----- hw/rtl/lg_row_cell.sv -----
// ============================================================================
// lg_row_cell: one grid row of the life automaton
// Holds one row; clears, edits one cell, steps one generation from its
// neighbor rows, or takes the row of the next cell during the dump.
// ============================================================================
module lg_row_cell import lg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          sel,
   input  row_type       edit_mask,
   input  row_type       above,
   input  row_type       below,
   input  row_type       shift_in,
   output row_type       row
);

   row_type row_ff;
   row_type row_in;

   always_comb begin
      row_in = row_ff;
      if (ctrl.clear) begin
         row_in = '0;
      end else if (ctrl.step) begin
         row_in = life_row(above, row_ff, below);
      end else if (ctrl.shift) begin
         row_in = shift_in;
      end else if (sel && ctrl.spawn) begin
         row_in = row_ff | edit_mask;
      end else if (sel && ctrl.kill) begin
         row_in = row_ff & ~edit_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row = row_ff;

endmodule

// ----- hw/rtl/life_automaton_grid.sv -----
// ============================================================================
// life_automaton_grid: bounded Conway life grid (B3/S23) with row dump
// Command in, GRID_ROWS row transfers out per command.
// ============================================================================
// Each accepted command (clear, kill, spawn, step) is applied to the grid at
// the edge that accepts it; the grid is then dumped row 0 first, one row per
// cycle while rsp is ready; a stall on rsp holds the dump. The grid lives in
// a chain of row cells: a step updates all rows together from their
// neighbors, and the dump rotates the chain by one row per transfer, so
// after the last row the grid is back in place. A new command is taken only
// when the dump is done. Out-of-grid kill/spawn leaves the grid alone and
// flags status on all rows.
module life_automaton_grid import lg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lg_req_if.sink   req_chan,
   lg_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [ROW_IDX_W-1:0] cnt_ff, cnt_in;
   logic                 status_ff, status_in;

   logic                 req_xfer, rsp_xfer, last;
   logic                 in_range;
   cell_ctrl_type        ctrl;
   row_type              edit_mask;
   logic [GRID_ROWS-1:0] row_sel;
   row_type              rows [GRID_ROWS];
   logic [ROW_IDX_W+ROW_NUM_W-1:0] idx_wide;
   logic [ROW_OUT_W-1:0] row_out;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   assign last     = (cnt_ff == ROW_IDX_W'(GRID_ROWS - 1));

   assign in_range = (req_chan.cell_x < COORD_W'(GRID_COLUMNS)) &&
                     (req_chan.cell_y < COORD_W'(GRID_ROWS));
   assign edit_mask = row_type'(1) << req_chan.cell_x[COL_IDX_W-1:0];

   always_comb begin
      ctrl       = '0;
      ctrl.shift = rsp_xfer;
      if (req_xfer) begin
         ctrl.clear = (kind_type'(req_chan.kind) == KIND_CLEAR);
         ctrl.step  = (kind_type'(req_chan.kind) == KIND_STEP);
         ctrl.kill  = (kind_type'(req_chan.kind) == KIND_KILL) && in_range;
         ctrl.spawn = (kind_type'(req_chan.kind) == KIND_SPAWN) && in_range;
      end
   end

   for (genvar i = 0; i < GRID_ROWS; i++) begin : g_row
      row_type above, below;
      assign row_sel[i] = (req_chan.cell_y[ROW_IDX_W-1:0] == ROW_IDX_W'(i));
      if (i == 0) begin : g_top
         assign above = '0;
      end else begin : g_mid_a
         assign above = rows[i-1];
      end
      if (i == GRID_ROWS - 1) begin : g_bot
         assign below = '0;
      end else begin : g_mid_b
         assign below = rows[i+1];
      end
      // dump rotates toward cell 0; the last cell takes cell 0's row
      lg_row_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sel       (row_sel[i]),
         .edit_mask (edit_mask),
         .above     (above),
         .below     (below),
         .shift_in  (rows[(i + 1) % GRID_ROWS]),
         .row       (rows[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in  = ST_EMIT;
               cnt_in    = '0;
               status_in = !in_range &&
                           ((kind_type'(req_chan.kind) == KIND_KILL) ||
                            (kind_type'(req_chan.kind) == KIND_SPAWN));
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         status_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

   assign idx_wide = {{ROW_NUM_W{1'b0}}, cnt_ff};

   always_comb begin
      row_out = '0;
      row_out[GRID_COLUMNS-1:0] = rows[0];
   end

   assign rsp_chan.valid     = (state_ff == ST_EMIT);
   assign rsp_chan.row_index = idx_wide[ROW_NUM_W-1:0];
   assign rsp_chan.row_cells = row_out;
   assign rsp_chan.last_row  = last;
   assign rsp_chan.status    = status_ff;

endmodule

// ----- hw/rtl/lg_checker.sv -----
// ============================================================================
// lg_checker: port-level checks for the life automaton grid
// Watches the request and row dump channels; bound to the top level.
// ============================================================================
module lg_checker import lg_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ROW_NUM_W-1:0] rsp_row_index,
   input logic [ROW_OUT_W-1:0] rsp_row_cells,
   input logic                 rsp_last_row,
   input logic                 rsp_status
);

   // stalled row holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_cells) &&
                                  $stable(rsp_row_index))
      else $error("rsp row changed while stalled");

   // the last row is the final grid row
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_row |-> rsp_row_index == ROW_NUM_W'(GRID_ROWS - 1))
      else $error("last_row on wrong row index");

   // rows of one dump follow each other with the same status
   a_next_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_row |=>
         rsp_valid && (rsp_row_index == ROW_NUM_W'($past(rsp_row_index) + 1'b1)) &&
         (rsp_status == $past(rsp_status)))
      else $error("dump rows out of sequence");

   // no command is taken while a dump is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("command transfer during dump");

endmodule

bind life_automaton_grid lg_checker u_lg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_row_index (rsp_chan.row_index),
   .rsp_row_cells (rsp_chan.row_cells),
   .rsp_last_row  (rsp_chan.last_row),
   .rsp_status    (rsp_chan.status)
);

// ----- dv/tb_life_automaton_grid.sv -----
// ----------------------------------------------------------------------------
// tb_life_automaton_grid: self-checking bench for the bounded life grid
// Drives clear/kill/spawn/step commands, keeps a behavioral copy of the grid,
// and checks every row of every dump in order. A directed table covers the
// corners, out-of-grid positions and edge-clipped patterns. Random commands
// follow, with bursts of idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_life_automaton_grid import lg_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum {PIN_NONE, PIN_OK, PIN_BAD_POS, PIN_EMPTY} pin_kind_type;

   typedef struct {
      kind_type         kind;
      logic [7:0]       cx;
      logic [7:0]       cy;
      pin_kind_type     pin;
   } command_row_type;

   typedef struct packed {
      logic [ROW_NUM_W-1:0] idx;
      logic [ROW_OUT_W-1:0] cells;
      logic                 last_flag;
      logic                 status;
   } grid_row_type;

   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_ITEMS   = 75;
   localparam int HOLD_CYCLES    = 300;

   // Pinned rows carry a known status, or a known empty grid.
   command_row_type directed_cmds [DIRECTED_COUNT] = '{
      '{KIND_CLEAR, 8'd0,   8'd0,   PIN_EMPTY},
      '{KIND_STEP,  8'd0,   8'd0,   PIN_EMPTY},
      '{KIND_SPAWN, 8'd0,   8'd0,   PIN_OK},
      '{KIND_SPAWN, 8'd63,  8'd15,  PIN_OK},
      '{KIND_SPAWN, 8'd63,  8'd0,   PIN_OK},
      '{KIND_SPAWN, 8'd0,   8'd15,  PIN_OK},
      '{KIND_SPAWN, 8'd0,   8'd0,   PIN_OK},
      '{KIND_KILL,  8'd5,   8'd5,   PIN_OK},
      '{KIND_SPAWN, 8'd64,  8'd0,   PIN_BAD_POS},
      '{KIND_KILL,  8'd0,   8'd16,  PIN_BAD_POS},
      '{KIND_SPAWN, 8'd255, 8'd255, PIN_BAD_POS},
      '{KIND_KILL,  8'd255, 8'd0,   PIN_BAD_POS},
      '{KIND_STEP,  8'd255, 8'd255, PIN_EMPTY},
      '{KIND_SPAWN, 8'd0,   8'd6,   PIN_OK},
      '{KIND_SPAWN, 8'd0,   8'd7,   PIN_OK},
      '{KIND_SPAWN, 8'd0,   8'd8,   PIN_OK},
      '{KIND_STEP,  8'd0,   8'd0,   PIN_NONE},
      '{KIND_STEP,  8'd0,   8'd0,   PIN_NONE},
      '{KIND_SPAWN, 8'd62,  8'd14,  PIN_OK},
      '{KIND_SPAWN, 8'd63,  8'd14,  PIN_OK},
      '{KIND_SPAWN, 8'd62,  8'd15,  PIN_OK},
      '{KIND_SPAWN, 8'd63,  8'd15,  PIN_OK},
      '{KIND_STEP,  8'd0,   8'd0,   PIN_NONE},
      '{KIND_KILL,  8'd63,  8'd15,  PIN_OK},
      '{KIND_CLEAR, 8'd255, 8'd255, PIN_EMPTY}
   };

   logic         clock;
   logic         reset;
   pin_kind_type offered_pin;
   bit           sender_idles;
   bit           receiver_idles;
   bit           hold_off_request;

   row_type      life_grid [GRID_ROWS];
   grid_row_type dump_rows_due [$];

   int fail_count;
   int commands_applied;
   int steps_applied;
   int off_grid_commands;
   int rows_checked;

   lg_req_if req_chan ();
   lg_rsp_if rsp_chan ();

   life_automaton_grid dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // B3/S23 on a copy of the grid; anything past an edge is dead.
   function automatic void advance_generation();
      row_type prev [GRID_ROWS];
      int      live;
      int      ny;
      int      nx;
      prev = life_grid;
      for (int y = 0; y < GRID_ROWS; y++) begin
         for (int x = 0; x < GRID_COLUMNS; x++) begin
            live = 0;
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dx = -1; dx <= 1; dx++) begin
                  ny = y + dy;
                  nx = x + dx;
                  if ((dy != 0 || dx != 0) && ny >= 0 && ny < GRID_ROWS
                      && nx >= 0 && nx < GRID_COLUMNS)
                     live += int'(prev[ny][nx]);
               end
            end
            life_grid[y][x] = (live == 3) || (prev[y][x] && live == 2);
         end
      end
   endfunction

   // Update the grid for one accepted command and queue its full dump.
   function automatic void apply_life_command(kind_type k, logic [7:0] cx,
                                              logic [7:0] cy, pin_kind_type pin);
      logic         flag;
      grid_row_type row;
      flag = 1'b0;
      commands_applied++;
      case (k)
         KIND_CLEAR: begin
            foreach (life_grid[y]) life_grid[y] = '0;
         end
         KIND_STEP: begin
            advance_generation();
            steps_applied++;
         end
         default: begin
            if (int'(cx) >= GRID_COLUMNS || int'(cy) >= GRID_ROWS) begin
               flag = 1'b1;
               off_grid_commands++;
            end else if (k == KIND_KILL) begin
               life_grid[cy][cx] = 1'b0;
            end else begin
               life_grid[cy][cx] = 1'b1;
            end
         end
      endcase
      for (int y = 0; y < GRID_ROWS; y++) begin
         row.idx       = ROW_NUM_W'(y);
         row.cells     = ROW_OUT_W'(life_grid[y]);
         row.last_flag = (y == GRID_ROWS - 1);
         row.status    = flag;
         case (pin)
            PIN_OK:      row.status = 1'b0;
            PIN_BAD_POS: row.status = 1'b1;
            PIN_EMPTY: begin
               row.status = 1'b0;
               row.cells  = '0;
            end
            default: ;
         endcase
         dump_rows_due.push_back(row);
      end
   endfunction

   function automatic void check_row_transfer();
      grid_row_type want;
      if (dump_rows_due.size() == 0) begin
         $error("row transfer with nothing expected: row_index %0d",
                rsp_chan.row_index);
         fail_count++;
         return;
      end
      want = dump_rows_due.pop_front();
      rows_checked++;
      if (rsp_chan.row_index !== want.idx) begin
         $error("row_index mismatch: expected %0d, actual %0d",
                want.idx, rsp_chan.row_index);
         fail_count++;
      end
      if (rsp_chan.row_cells !== want.cells) begin
         $error("row_cells mismatch (row %0d): expected %h, actual %h",
                want.idx, want.cells, rsp_chan.row_cells);
         fail_count++;
      end
      if (rsp_chan.last_row !== want.last_flag) begin
         $error("last_row mismatch (row %0d): expected %0b, actual %0b",
                want.idx, want.last_flag, rsp_chan.last_row);
         fail_count++;
      end
      if (rsp_chan.status !== want.status) begin
         $error("status mismatch (row %0d): expected %0b, actual %0b",
                want.idx, want.status, rsp_chan.status);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_row_transfer();
         if (req_chan.valid && req_chan.ready)
            apply_life_command(kind_type'(req_chan.kind), req_chan.cell_x,
                               req_chan.cell_y, offered_pin);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic offer_command(kind_type k, logic [7:0] cx, logic [7:0] cy,
                                pin_kind_type pin);
      int gap;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  = 1'b1;
      req_chan.kind   = k;
      req_chan.cell_x = cx;
      req_chan.cell_y = cy;
      offered_pin     = pin;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Output side: random stall bursts, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_chan.ready = 1'b0;
            for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 15);
            rsp_chan.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int         pick;
      int         anchor_x;
      int         anchor_y;
      kind_type   k;
      logic [7:0] cx;
      logic [7:0] cy;
      req_chan.valid   = 1'b0;
      req_chan.kind    = KIND_CLEAR;
      req_chan.cell_x  = '0;
      req_chan.cell_y  = '0;
      offered_pin      = PIN_NONE;
      sender_idles     = 1'b1;
      receiver_idles   = 1'b1;
      hold_off_request = 1'b0;
      fail_count       = 0;
      commands_applied = 0;
      steps_applied    = 0;
      off_grid_commands = 0;
      rows_checked     = 0;
      anchor_x         = 0;
      anchor_y         = 0;
      foreach (life_grid[y]) life_grid[y] = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_cmds[i])
         offer_command(directed_cmds[i].kind, directed_cmds[i].cx,
                       directed_cmds[i].cy, directed_cmds[i].pin);

      // Spawns cluster in a 5x5 window so generations have something to do;
      // the window moves on each clear and often sits on an edge.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 30)
            hold_off_request = 1'b1;
         if (i == RANDOM_ITEMS - 20) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 5)       k = KIND_CLEAR;
         else if (pick < 20) k = KIND_KILL;
         else if (pick < 65) k = KIND_SPAWN;
         else                k = KIND_STEP;
         if (k == KIND_CLEAR || i == 0) begin
            case ($urandom_range(0, 2))
               0: anchor_x = 0;
               1: anchor_x = GRID_COLUMNS - 5;
               default: anchor_x = $urandom_range(0, GRID_COLUMNS - 5);
            endcase
            anchor_y = ($urandom_range(0, 1) == 0) ? GRID_ROWS - 5
                                                   : $urandom_range(0, GRID_ROWS - 5);
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            cx = 8'($urandom_range(GRID_COLUMNS, 255));
            cy = 8'($urandom_range(0, 255));
         end else if (pick < 15) begin
            cx = 8'($urandom_range(0, 255));
            cy = 8'($urandom_range(GRID_ROWS, 255));
         end else if (pick < 25) begin
            cx = 8'($urandom_range(0, GRID_COLUMNS - 1));
            cy = 8'($urandom_range(0, GRID_ROWS - 1));
         end else begin
            cx = 8'(anchor_x + $urandom_range(0, 4));
            cy = 8'(anchor_y + $urandom_range(0, 4));
         end
         offer_command(k, cx, cy, PIN_NONE);
      end
      req_chan.valid = 1'b0;

      while (dump_rows_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Applied %0d commands: %0d generations, %0d off-grid kill/spawn",
               commands_applied, steps_applied, off_grid_commands);
      $display("Checked %0d row transfers, %0d mismatches", rows_checked,
               fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/lg_pkg.sv
hw/rtl/lg_if.sv
hw/rtl/lg_row_cell.sv
hw/rtl/life_automaton_grid.sv
hw/rtl/lg_checker.sv
dv/tb_life_automaton_grid.sv
